/* design/lidar_range_voxel_downsampler_macros.svh */
// Assertion macros for the lidar range voxel downsampler.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef LIDAR_RANGE_VOXEL_DOWNSAMPLER_MACROS_SVH
`define LIDAR_RANGE_VOXEL_DOWNSAMPLER_MACROS_SVH
`ifndef SYNTH
// check a property at every clock edge out of reset
`define LRVD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// check that a condition in the next cycle follows from a trigger
`define LRVD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LRVD_ASSERT(lbl, prop, msg)
`define LRVD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* design/lrvd_pkg.sv */
// Shared types and constants of the lidar range voxel downsampler.
// No dependencies; the front, back and top files import it.
package lrvd_pkg;

    localparam int IN_BITS      = 20;
    localparam int TIME_BITS    = 32;
    localparam int CFG_BITS     = 19;
    localparam int IDX_BITS     = 3;
    localparam int INV_BITS     = 17;
    localparam int CNT_BITS     = 11;
    localparam int OUT_IDX_BITS = 10;
    localparam int SQ_BITS      = 2 * CFG_BITS;
    localparam int R2_BITS      = 2 * IN_BITS;
    localparam int HASH_BITS    = 32;
    localparam int EPOCH_BITS   = 8;

    localparam int PT_CAP_MAX      = 1024;
    localparam int DEF_TABLE_DEPTH = 2048;
    localparam int DEF_COORD_BITS  = 20;
    localparam int JOBQ_DEPTH      = 4;
    localparam int OUTQ_DEPTH      = 2;

    localparam logic [HASH_BITS-1:0] HASH_MUL [3] = '{32'd73856093, 32'd19349663, 32'd83492791};

    localparam logic [CFG_BITS-1:0] RST_LO_MM    = 19'd0;
    localparam logic [CFG_BITS-1:0] RST_HI_MM    = 19'd100000;
    localparam logic [CFG_BITS-1:0] RST_BLIND    = 19'd500;
    localparam logic [INV_BITS-1:0] RST_INV_LEAF = 17'd1311;
    localparam logic [CNT_BITS-1:0] RST_PT_CAP   = 11'd1024;

    typedef enum logic [IDX_BITS-1:0] {
        CFG_LO_MM    = 3'd0,
        CFG_HI_MM    = 3'd1,
        CFG_BLIND    = 3'd2,
        CFG_INV_LEAF = 3'd3,
        CFG_PT_CAP   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_BITS-1:0] lo_mm;
        logic [CFG_BITS-1:0] hi_mm;
        logic [CFG_BITS-1:0] blind_mm;
        logic [INV_BITS-1:0] inv_leaf;
        logic [CNT_BITS-1:0] pt_cap;
    } t_cfg;

    typedef struct packed {
        logic signed [IN_BITS-1:0] point_x;
        logic signed [IN_BITS-1:0] point_y;
        logic signed [IN_BITS-1:0] point_z;
        logic [TIME_BITS-1:0]      time_rel;
        logic                      finite;
        logic                      last_in_frame;
    } t_item_in;

    typedef struct packed {
        logic signed [IN_BITS-1:0] out_x;
        logic signed [IN_BITS-1:0] out_y;
        logic signed [IN_BITS-1:0] out_z;
        logic [TIME_BITS-1:0]      out_time;
        logic [OUT_IDX_BITS-1:0]   out_index;
    } t_item_out;

endpackage

/* design/lrvd_fifo.sv */
// Small register queue, used between front and back and for results.
// Depends on nothing; DEPTH must be a power of two.
module lrvd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    // store a word
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

/* design/lrvd_front.sv */
// Front pipeline: range filter, voxel key, hash and start slot per point.
// Depends on lrvd_pkg.
module lrvd_front import lrvd_pkg::*; #(
    parameter  int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter  int COORD_BITS  = DEF_COORD_BITS,
    localparam int AW          = $clog2(TABLE_DEPTH),
    localparam int KEY_W       = 3 * COORD_BITS,
    localparam int JOB_W       = $bits(t_item_in) + 1 + KEY_W + AW
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_push,
    input  t_item_in         i_item,
    output logic             o_full,
    output logic             o_job_valid,
    output logic [JOB_W-1:0] o_job,
    input  logic             i_job_full
);
    localparam int MOD_SHIFT = HASH_BITS + AW;
    localparam logic [HASH_BITS:0] RECIP =
        (HASH_BITS + 1)'((65'(1) << MOD_SHIFT) / TABLE_DEPTH);
    localparam logic [AW:0] DEPTH_V = (AW + 1)'(TABLE_DEPTH);
    localparam int VP_W = IN_BITS + INV_BITS + 1;

    typedef struct packed {
        t_item_in         item;
        logic             pass;
        logic [KEY_W-1:0] key;
        logic [AW-1:0]    slot;
    } t_job;

    logic adv;

    // thresholds squared and registered from the current config
    logic [SQ_BITS-1:0] r_min_sq, r_max_sq, r_blind_sq;
    always_ff @(posedge i_clk) begin
        r_min_sq   <= i_cfg.lo_mm * i_cfg.lo_mm;
        r_max_sq   <= i_cfg.hi_mm * i_cfg.hi_mm;
        r_blind_sq <= i_cfg.blind_mm * i_cfg.blind_mm;
    end

    // stage 1: squares and voxel products
    logic signed [IN_BITS-1:0]   c_in [3];
    logic signed [R2_BITS-1:0]   sq   [3];
    logic signed [VP_W-1:0]      vp   [3];
    logic [R2_BITS-2:0]          r1_sq [3];
    logic signed [VP_W-1:0]      r1_vp [3];
    t_item_in                    r1_item;
    logic                        r1_v;

    assign c_in[0] = i_item.point_x;
    assign c_in[1] = i_item.point_y;
    assign c_in[2] = i_item.point_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sq[i] = c_in[i] * c_in[i];
            vp[i] = c_in[i] * $signed({1'b0, i_cfg.inv_leaf});
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_item <= i_item;
            for (int i = 0; i < 3; i++) begin
                r1_sq[i] <= sq[i][R2_BITS-2:0];
                r1_vp[i] <= vp[i];
            end
        end
    end

    // stage 2: range compare, key fields, per-field hash products
    logic [R2_BITS-1:0]    r2sum;
    logic                  pass1;
    logic [COORD_BITS-1:0] kf  [3];
    logic [HASH_BITS-1:0]  kse [3];
    logic [HASH_BITS-1:0]  hp  [3];
    logic [HASH_BITS-1:0]  r2_hp [3];
    logic [KEY_W-1:0]      r2_key;
    logic                  r2_pass;
    t_item_in              r2_item;
    logic                  r2_v;

    always_comb begin
        r2sum = R2_BITS'(r1_sq[0]) + R2_BITS'(r1_sq[1]) + R2_BITS'(r1_sq[2]);
        pass1 = r1_item.finite &&
                !((r2sum < R2_BITS'(r_min_sq)) || (r2sum > R2_BITS'(r_max_sq)) ||
                  (r2sum < R2_BITS'(r_blind_sq)));
        for (int i = 0; i < 3; i++) begin
            // floor by arithmetic shift, keep the low key bits
            kf[i]  = r1_vp[i][16 +: COORD_BITS];
            kse[i] = {{(HASH_BITS - COORD_BITS){kf[i][COORD_BITS-1]}}, kf[i]};
            hp[i]  = kse[i] * HASH_MUL[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_item <= r1_item;
            r2_pass <= pass1;
            r2_key  <= {kf[0], kf[1], kf[2]};
            for (int i = 0; i < 3; i++) begin
                r2_hp[i] <= hp[i];
            end
        end
    end

    // stage 3: combine hash
    logic [HASH_BITS-1:0] r3_h;
    logic [KEY_W-1:0]     r3_key;
    logic                 r3_pass;
    t_item_in             r3_item;
    logic                 r3_v;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_item <= r2_item;
            r3_pass <= r2_pass;
            r3_key  <= r2_key;
            r3_h    <= r2_hp[0] ^ r2_hp[1] ^ r2_hp[2];
        end
    end

    // stage 4: reciprocal product for the slot quotient
    logic [2*HASH_BITS:0] r4_hm;
    logic [HASH_BITS-1:0] r4_h;
    logic [KEY_W-1:0]     r4_key;
    logic                 r4_pass;
    t_item_in             r4_item;
    logic                 r4_v;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_item <= r3_item;
            r4_pass <= r3_pass;
            r4_key  <= r3_key;
            r4_h    <= r3_h;
            r4_hm   <= r3_h * RECIP;
        end
    end

    // stage 5: quotient times depth
    logic [HASH_BITS-1:0] q4;
    logic [HASH_BITS-1:0] r5_qd;
    logic [HASH_BITS-1:0] r5_h;
    logic [KEY_W-1:0]     r5_key;
    logic                 r5_pass;
    t_item_in             r5_item;
    logic                 r5_v;

    assign q4 = HASH_BITS'(r4_hm >> MOD_SHIFT);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_item <= r4_item;
            r5_pass <= r4_pass;
            r5_key  <= r4_key;
            r5_h    <= r4_h;
            r5_qd   <= q4 * HASH_BITS'(TABLE_DEPTH);
        end
    end

    // remainder with one correction step
    logic [HASH_BITS-1:0] diff;
    logic [AW:0]          rem;
    logic [AW:0]          rem_c;
    t_job                 job;

    always_comb begin
        diff  = r5_h - r5_qd;
        rem   = diff[AW:0];
        rem_c = (rem >= DEPTH_V) ? (rem - DEPTH_V) : rem;
        job.item = r5_item;
        job.pass = r5_pass;
        job.key  = r5_key;
        job.slot = rem_c[AW-1:0];
    end

    // hold the whole pipe when the queue cannot take the oldest word
    assign adv         = !(r5_v && i_job_full);
    assign o_full      = !adv;
    assign o_job_valid = r5_v;
    assign o_job       = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (adv) begin
            r1_v <= i_push;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end
endmodule

/* design/lrvd_back.sv */
// Back end: hash table probe and insert, per-frame count and result issue.
// Depends on lrvd_pkg.
module lrvd_back import lrvd_pkg::*; #(
    parameter  int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter  int COORD_BITS  = DEF_COORD_BITS,
    localparam int AW          = $clog2(TABLE_DEPTH),
    localparam int KEY_W       = 3 * COORD_BITS,
    localparam int JOB_W       = $bits(t_item_in) + 1 + KEY_W + AW
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_job_empty,
    input  logic [JOB_W-1:0] i_job,
    output logic             o_job_pop,
    input  logic             i_out_full,
    output logic             o_out_push,
    output t_item_out        o_out_item,
    output logic             o_clearing
);
    localparam int ENT_W = EPOCH_BITS + KEY_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

    typedef struct packed {
        t_item_in         item;
        logic             pass;
        logic [KEY_W-1:0] key;
        logic [AW-1:0]    slot;
    } t_job;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_CHECK = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [EPOCH_BITS-1:0] r_epoch, n_epoch;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic [AW-1:0]         r_addr, n_addr;
    logic [AW-1:0]         r_probe, n_probe;
    t_job                  r_job, n_job;
    t_job                  job_in;
    logic [ENT_W-1:0]      r_mem [TABLE_DEPTH];
    logic [ENT_W-1:0]      r_rd_data;
    logic                  mem_we;
    logic [ENT_W-1:0]      mem_wdata;
    logic [CNT_BITS-1:0]   limit;
    logic                  done, done_last, emit;
    t_item_in              emit_src;

    assign job_in = i_job;
    assign limit  = (i_cfg.pt_cap < CNT_BITS'(PT_CAP_MAX)) ?
                    i_cfg.pt_cap : CNT_BITS'(PT_CAP_MAX);

    // table storage: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= mem_wdata;
        end
        r_rd_data <= r_mem[r_addr];
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_epoch   = r_epoch;
        n_count   = r_count;
        n_addr    = r_addr;
        n_probe   = r_probe;
        n_job     = r_job;
        mem_we    = 1'b0;
        mem_wdata = {r_epoch, r_job.key};
        o_job_pop = 1'b0;
        emit      = 1'b0;
        emit_src  = r_job.item;
        done      = 1'b0;
        done_last = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (r_addr == LAST_SLOT) begin
                    n_state = ST_IDLE;
                    n_epoch = EPOCH_BITS'(1);
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (!i_job_empty && !i_out_full) begin
                    o_job_pop = 1'b1;
                    n_job     = job_in;
                    emit_src  = job_in.item;
                    if (!job_in.pass || (r_count >= limit)) begin
                        done      = 1'b1;
                        done_last = job_in.item.last_in_frame;
                    end else if (i_cfg.inv_leaf == '0) begin
                        emit      = 1'b1;
                        done      = 1'b1;
                        done_last = job_in.item.last_in_frame;
                    end else begin
                        n_addr  = job_in.slot;
                        n_probe = '0;
                        n_state = ST_WAIT;
                    end
                end
            end
            ST_WAIT: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (r_rd_data[ENT_W-1 -: EPOCH_BITS] != r_epoch) begin
                    // free slot: claim it
                    mem_we    = 1'b1;
                    emit      = 1'b1;
                    done      = 1'b1;
                    done_last = r_job.item.last_in_frame;
                end else if (r_rd_data[KEY_W-1:0] == r_job.key ||
                             r_probe == LAST_SLOT) begin
                    // duplicate voxel or table full: drop
                    done      = 1'b1;
                    done_last = r_job.item.last_in_frame;
                end else begin
                    n_probe = r_probe + 1'b1;
                    n_addr  = (r_addr == LAST_SLOT) ? '0 : r_addr + 1'b1;
                    n_state = ST_WAIT;
                end
            end
            default: begin
                n_state = ST_CLEAR;
                n_addr  = '0;
            end
        endcase

        if (emit) begin
            n_count = r_count + 1'b1;
        end
        if (done) begin
            n_state = ST_IDLE;
        end
        // frame end: new epoch, sweep when the epoch wraps
        if (done_last) begin
            n_count = '0;
            n_epoch = r_epoch + 1'b1;
            if (r_epoch == '1) begin
                n_state = ST_CLEAR;
                n_addr  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_epoch <= '0;
            r_count <= '0;
            r_addr  <= '0;
            r_probe <= '0;
        end else begin
            r_state <= n_state;
            r_epoch <= n_epoch;
            r_count <= n_count;
            r_addr  <= n_addr;
            r_probe <= n_probe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

    // result word
    always_comb begin
        o_out_item.out_x     = emit_src.point_x;
        o_out_item.out_y     = emit_src.point_y;
        o_out_item.out_z     = emit_src.point_z;
        o_out_item.out_time  = emit_src.time_rel;
        o_out_item.out_index = r_count[OUT_IDX_BITS-1:0];
    end

    assign o_out_push = emit;
    assign o_clearing = (r_state == ST_CLEAR);
endmodule

/* design/lidar_range_voxel_downsampler.sv */
// Lidar range voxel downsampler. Each point passes through the front pipeline (squares,
// range test, voxel key, hash, start slot) and then waits in a four-word queue for the
// back end. The back end takes a point that is dropped, or that is kept without voxel
// lookup, straight from its idle state; a point that is looked up goes through a
// registered table read and then a compare for each table slot probed. Points are
// accepted one per cycle while the queue has room. After reset, and after every 255th
// frame end, the table is swept slot by slot, during which full stays high;
// configuration writes are taken at any time.
// Depends on lrvd_pkg, lrvd_fifo, lrvd_front, lrvd_back and the macro header.
`include "lidar_range_voxel_downsampler_macros.svh"
module lidar_range_voxel_downsampler import lrvd_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int COORD_BITS  = DEF_COORD_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    input  t_item_in            i_item,
    output logic                full,
    output logic                empty,
    input  logic                pop,
    output t_item_out           o_result,
    input  logic                i_cfg_we,
    input  logic [IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0] i_cfg_data
);
    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int KEY_W = 3 * COORD_BITS;
    localparam int JOB_W = $bits(t_item_in) + 1 + KEY_W + AW;
    localparam int OUT_W = $bits(t_item_out);

    t_cfg             r_cfg;
    logic             clearing;
    logic             front_full;
    logic             job_valid, job_full, job_empty, job_pop, job_push;
    logic [JOB_W-1:0] job_front, job_back;
    logic             out_push, out_full;
    t_item_out        out_item;
    logic [OUT_W-1:0] out_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lo_mm    <= RST_LO_MM;
            r_cfg.hi_mm    <= RST_HI_MM;
            r_cfg.blind_mm <= RST_BLIND;
            r_cfg.inv_leaf <= RST_INV_LEAF;
            r_cfg.pt_cap   <= RST_PT_CAP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LO_MM:    r_cfg.lo_mm    <= i_cfg_data;
                CFG_HI_MM:    r_cfg.hi_mm    <= i_cfg_data;
                CFG_BLIND:    r_cfg.blind_mm <= i_cfg_data;
                CFG_INV_LEAF: r_cfg.inv_leaf <= i_cfg_data[INV_BITS-1:0];
                CFG_PT_CAP:   r_cfg.pt_cap   <= i_cfg_data[CNT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // hold off new points during a table sweep
    assign full = front_full || clearing;

    lrvd_front #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_push     (push && !clearing),
        .i_item     (i_item),
        .o_full     (front_full),
        .o_job_valid(job_valid),
        .o_job      (job_front),
        .i_job_full (job_full)
    );

    assign job_push = job_valid && !job_full;

    lrvd_fifo #(
        .WIDTH(JOB_W),
        .DEPTH(JOBQ_DEPTH)
    ) u_job_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (job_push),
        .i_data (job_front),
        .o_full (job_full),
        .i_pop  (job_pop),
        .o_data (job_back),
        .o_empty(job_empty)
    );

    lrvd_back #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_job_empty(job_empty),
        .i_job      (job_back),
        .o_job_pop  (job_pop),
        .i_out_full (out_full),
        .o_out_push (out_push),
        .o_out_item (out_item),
        .o_clearing (clearing)
    );

    lrvd_fifo #(
        .WIDTH(OUT_W),
        .DEPTH(OUTQ_DEPTH)
    ) u_out_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (out_push),
        .i_data (out_item),
        .o_full (out_full),
        .i_pop  (pop),
        .o_data (out_data),
        .o_empty(empty)
    );

    assign o_result = t_item_out'(out_data);

    // back end only issues a result into a free slot
    `LRVD_ASSERT(a_out_room, out_push |-> !out_full, "result issued into full queue")
    // back end only takes a word when a result slot is free
    `LRVD_ASSERT(a_pop_room, job_pop |-> (!out_full && !job_empty), "job taken without room")
    // no result appears without an issue
    `LRVD_ASSERT_NEXT(a_no_phantom, empty && !out_push, empty, "result from nowhere")
endmodule
